>>> rtl/vcf_pkg.sv
// Package: mode, command and error codes for the vending controller.
`timescale 1ns / 1ps

package vcf_pkg;

   localparam int unsigned CMD_WIDTH   = 3;
   localparam int unsigned ERR_WIDTH   = 3;
   localparam int unsigned CODE_WIDTH  = 3;
   localparam int unsigned FIELD_WIDTH = 16;
   localparam int unsigned PIN_WIDTH   = 17;

   localparam logic [PIN_WIDTH-1:0] PIN_RESET = 17'd54321;

   localparam logic [CMD_WIDTH-1:0] CMD_INSERT   = 3'd0;
   localparam logic [CMD_WIDTH-1:0] CMD_REFUND   = 3'd1;
   localparam logic [CMD_WIDTH-1:0] CMD_SELECT   = 3'd2;
   localparam logic [CMD_WIDTH-1:0] CMD_DISPENSE = 3'd3;
   localparam logic [CMD_WIDTH-1:0] CMD_PIN      = 3'd4;
   localparam logic [CMD_WIDTH-1:0] CMD_RESTOCK  = 3'd5;
   localparam logic [CMD_WIDTH-1:0] CMD_EXIT     = 3'd6;

   localparam logic [ERR_WIDTH-1:0] ERR_NONE   = 3'd0;
   localparam logic [ERR_WIDTH-1:0] ERR_STATE  = 3'd1;
   localparam logic [ERR_WIDTH-1:0] ERR_STOCK  = 3'd2;
   localparam logic [ERR_WIDTH-1:0] ERR_CREDIT = 3'd3;
   localparam logic [ERR_WIDTH-1:0] ERR_PIN    = 3'd4;

   localparam logic [CODE_WIDTH-1:0] CODE_EMPTY    = 3'd0;
   localparam logic [CODE_WIDTH-1:0] CODE_IDLE     = 3'd1;
   localparam logic [CODE_WIDTH-1:0] CODE_CREDIT   = 3'd2;
   localparam logic [CODE_WIDTH-1:0] CODE_DISPENSE = 3'd3;
   localparam logic [CODE_WIDTH-1:0] CODE_MAINT    = 3'd4;

   typedef enum logic [4:0] {
      MODE_EMPTY    = 5'b00001,
      MODE_IDLE     = 5'b00010,
      MODE_CREDIT   = 5'b00100,
      MODE_DISPENSE = 5'b01000,
      MODE_MAINT    = 5'b10000
   } mode_type;

   function automatic logic [CODE_WIDTH-1:0] mode_code(input mode_type mode);
      logic [CODE_WIDTH-1:0] code;
      unique case (mode)
         MODE_EMPTY:    code = CODE_EMPTY;
         MODE_IDLE:     code = CODE_IDLE;
         MODE_CREDIT:   code = CODE_CREDIT;
         MODE_DISPENSE: code = CODE_DISPENSE;
         MODE_MAINT:    code = CODE_MAINT;
         default:       code = CODE_EMPTY;
      endcase
      return code;
   endfunction

endpackage

>>> rtl/vending_controller_fsm_unit.sv
// Top level: vending controller state machine with credit and stock counters.
//
//   channel | direction | handshake          | payload
//   req     | in        | req_valid/ready    | cmd, money, bars, stock added, pin
//   rsp     | out       | rsp_valid/ready    | accepted, error, mode, credit, stock
//   csr     | in        | csr_we             | access pin
//
// One transaction a cycle unless rsp stalls; rsp is driven from the result register.
// The input register feeds one pass of compare/add/subtract into the result register.
// Synchronous reset empties both registers, clears the counters and loads the default pin.
// A stalled rsp holds the result; req stays ready while the input register can advance.
`timescale 1ns / 1ps

module vending_controller_fsm_unit #(
   parameter int unsigned COUNT_WIDTH = 16
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic [vcf_pkg::CMD_WIDTH-1:0]       req_cmd,
   input  logic [vcf_pkg::FIELD_WIDTH-1:0]     req_money_amount,
   input  logic [vcf_pkg::FIELD_WIDTH-1:0]     req_bars_wanted,
   input  logic [vcf_pkg::FIELD_WIDTH-1:0]     req_stock_added,
   input  logic [vcf_pkg::PIN_WIDTH-1:0]       req_pin_entered,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic                                rsp_accepted,
   output logic [vcf_pkg::ERR_WIDTH-1:0]       rsp_error_code,
   output logic [vcf_pkg::CODE_WIDTH-1:0]      rsp_mode_now,
   output logic [vcf_pkg::FIELD_WIDTH-1:0]     rsp_credit_level,
   output logic [vcf_pkg::FIELD_WIDTH-1:0]     rsp_stock_level,
   input  logic                                csr_we,
   input  logic [vcf_pkg::PIN_WIDTH-1:0]       csr_wdata
);

   localparam int unsigned SumWidth =
      ((COUNT_WIDTH > vcf_pkg::FIELD_WIDTH) ? COUNT_WIDTH : vcf_pkg::FIELD_WIDTH) + 1;
   localparam logic [SumWidth-1:0] CountMax =
      {{(SumWidth-COUNT_WIDTH){1'b0}}, {COUNT_WIDTH{1'b1}}};

   logic                              in_valid_ff, in_valid_in;
   logic [vcf_pkg::CMD_WIDTH-1:0]     cmd_ff;
   logic [vcf_pkg::FIELD_WIDTH-1:0]   money_ff, bars_ff, added_ff;
   logic [vcf_pkg::PIN_WIDTH-1:0]     pin_ff;

   logic                              out_valid_ff, out_valid_in;
   logic                              accepted_ff;
   logic [vcf_pkg::ERR_WIDTH-1:0]     error_ff;
   logic [vcf_pkg::CODE_WIDTH-1:0]    mode_code_ff;
   logic [vcf_pkg::FIELD_WIDTH-1:0]   credit_out_ff, stock_out_ff;

   vcf_pkg::mode_type                 mode_ff, mode_in;
   logic [COUNT_WIDTH-1:0]            credit_ff, credit_in;
   logic [COUNT_WIDTH-1:0]            stock_ff, stock_in;
   logic [vcf_pkg::PIN_WIDTH-1:0]     access_pin_ff;

   logic                              advance, take;
   logic [vcf_pkg::ERR_WIDTH-1:0]     err;
   logic [SumWidth-1:0]               credit_ext, stock_ext, money_ext, bars_ext, added_ext;
   logic [SumWidth-1:0]               credit_sum, stock_sum, credit_left, stock_left;
   logic [SumWidth-1:0]               credit_in_ext, stock_in_ext;

   assign advance     = in_valid_ff && (!out_valid_ff || rsp_ready);
   assign req_ready   = !in_valid_ff || advance;
   assign take        = req_valid && req_ready;
   assign in_valid_in = take || (in_valid_ff && !advance);
   assign out_valid_in = advance || (out_valid_ff && !rsp_ready);

   assign credit_ext  = SumWidth'(credit_ff);
   assign stock_ext   = SumWidth'(stock_ff);
   assign money_ext   = SumWidth'(money_ff);
   assign bars_ext    = SumWidth'(bars_ff);
   assign added_ext   = SumWidth'(added_ff);
   assign credit_sum  = credit_ext + money_ext;
   assign stock_sum   = stock_ext + added_ext;
   assign credit_left = credit_ext - bars_ext;
   assign stock_left  = stock_ext - bars_ext;

   always_comb begin
      mode_in   = mode_ff;
      credit_in = credit_ff;
      stock_in  = stock_ff;
      err       = vcf_pkg::ERR_STATE;
      unique case (cmd_ff)
         vcf_pkg::CMD_INSERT: begin
            if (mode_ff == vcf_pkg::MODE_IDLE || mode_ff == vcf_pkg::MODE_CREDIT) begin
               credit_in = (credit_sum > CountMax) ? CountMax[COUNT_WIDTH-1:0]
                                                   : credit_sum[COUNT_WIDTH-1:0];
               mode_in   = vcf_pkg::MODE_CREDIT;
               err       = vcf_pkg::ERR_NONE;
            end
         end
         vcf_pkg::CMD_REFUND: begin
            if (mode_ff == vcf_pkg::MODE_CREDIT) begin
               credit_in = '0;
               mode_in   = vcf_pkg::MODE_IDLE;
               err       = vcf_pkg::ERR_NONE;
            end
         end
         vcf_pkg::CMD_SELECT: begin
            if (mode_ff == vcf_pkg::MODE_CREDIT) begin
               priority if (stock_ext < bars_ext) begin
                  err = vcf_pkg::ERR_STOCK;
               end else if (credit_ext < bars_ext) begin
                  err = vcf_pkg::ERR_CREDIT;
               end else begin
                  stock_in  = stock_left[COUNT_WIDTH-1:0];
                  credit_in = credit_left[COUNT_WIDTH-1:0];
                  mode_in   = vcf_pkg::MODE_DISPENSE;
                  err       = vcf_pkg::ERR_NONE;
               end
            end
         end
         vcf_pkg::CMD_DISPENSE: begin
            if (mode_ff == vcf_pkg::MODE_DISPENSE) begin
               priority if (stock_ff == '0) begin
                  mode_in = vcf_pkg::MODE_EMPTY;
               end else if (credit_ff == '0) begin
                  mode_in = vcf_pkg::MODE_IDLE;
               end else begin
                  mode_in = vcf_pkg::MODE_CREDIT;
               end
               err = vcf_pkg::ERR_NONE;
            end
         end
         vcf_pkg::CMD_PIN: begin
            if (mode_ff == vcf_pkg::MODE_EMPTY || mode_ff == vcf_pkg::MODE_IDLE) begin
               if (pin_ff == access_pin_ff) begin
                  mode_in = vcf_pkg::MODE_MAINT;
                  err     = vcf_pkg::ERR_NONE;
               end else begin
                  err = vcf_pkg::ERR_PIN;
               end
            end
         end
         vcf_pkg::CMD_RESTOCK: begin
            if (mode_ff == vcf_pkg::MODE_MAINT) begin
               stock_in = (stock_sum > CountMax) ? CountMax[COUNT_WIDTH-1:0]
                                                 : stock_sum[COUNT_WIDTH-1:0];
               err      = vcf_pkg::ERR_NONE;
            end
         end
         vcf_pkg::CMD_EXIT: begin
            if (mode_ff == vcf_pkg::MODE_MAINT) begin
               mode_in = (stock_ff == '0) ? vcf_pkg::MODE_EMPTY : vcf_pkg::MODE_IDLE;
               err     = vcf_pkg::ERR_NONE;
            end
         end
         default: begin
            err = vcf_pkg::ERR_STATE;
         end
      endcase
   end

   assign credit_in_ext = SumWidth'(credit_in);
   assign stock_in_ext  = SumWidth'(stock_in);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff   <= 1'b0;
         out_valid_ff  <= 1'b0;
         mode_ff       <= vcf_pkg::MODE_EMPTY;
         credit_ff     <= '0;
         stock_ff      <= '0;
         access_pin_ff <= vcf_pkg::PIN_RESET;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         if (advance) begin
            mode_ff   <= mode_in;
            credit_ff <= credit_in;
            stock_ff  <= stock_in;
         end
         if (csr_we) begin
            access_pin_ff <= csr_wdata;
         end
      end
   end

   // hold payload until the next transaction moves in
   always_ff @(posedge clock) begin
      if (take) begin
         cmd_ff   <= req_cmd;
         money_ff <= req_money_amount;
         bars_ff  <= req_bars_wanted;
         added_ff <= req_stock_added;
         pin_ff   <= req_pin_entered;
      end
      if (advance) begin
         accepted_ff   <= (err == vcf_pkg::ERR_NONE);
         error_ff      <= err;
         mode_code_ff  <= vcf_pkg::mode_code(mode_in);
         credit_out_ff <= credit_in_ext[vcf_pkg::FIELD_WIDTH-1:0];
         stock_out_ff  <= stock_in_ext[vcf_pkg::FIELD_WIDTH-1:0];
      end
   end

   assign rsp_valid        = out_valid_ff;
   assign rsp_accepted     = accepted_ff;
   assign rsp_error_code   = error_ff;
   assign rsp_mode_now     = mode_code_ff;
   assign rsp_credit_level = credit_out_ff;
   assign rsp_stock_level  = stock_out_ff;

endmodule
